[rtl/core/ucbs_pkg.sv]
package ucbs_pkg;

  localparam int unsigned MaxChildren = 64;
  localparam int unsigned CountW = $clog2(MaxChildren + 1);

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic signed [39:0] ScoreMin = 40'sh80_0000_0000;
  localparam logic signed [39:0] ScoreMax = 40'sh7F_FFFF_FFFF;

  // controller states
  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StLnSq   = 8'b0000_0010,
    StLnMul  = 8'b0000_0100,
    StDiv    = 8'b0000_1000,
    StSqrt   = 8'b0001_0000,
    StScore  = 8'b0010_0000,
    StUpdate = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input request
    logic ln_init;    // start log computation
    logic ln_step;    // one squaring round
    logic ln_mul0;    // ln2 scaling, low partial product
    logic ln_mul1;    // ln2 scaling, high partial product
    logic div_init;   // start both divisions
    logic div_step;   // one quotient bit
    logic sqrt_init;  // start square root
    logic sqrt_step;  // one root bit
    logic score;      // form and saturate score
    logic update;     // update running best
    logic clear;      // clear selection after result
  } ucbs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic first;     // no child counted yet
    logic overflow;  // count has reached the limit
    logic skip;      // child is not scored
    logic last;      // captured request is the last child
  } ucbs_sts_t;

endpackage

[rtl/core/ucbs_in_if.sv]
interface ucbs_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] parent_visits;
  logic [23:0] child_visits;
  logic signed [31:0] child_value;
  logic        last_child;

  modport source (output valid, parent_visits, child_visits, child_value, last_child,
                  input ready);
  modport sink (input valid, parent_visits, child_visits, child_value, last_child,
                output ready);
endinterface

[rtl/core/ucbs_out_if.sv]
interface ucbs_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  chosen_index;
  logic        chosen_unvisited;
  logic signed [39:0] chosen_score;
  logic        too_many_children;

  modport source (output valid, chosen_index, chosen_unvisited, chosen_score,
                  too_many_children, input ready);
  modport sink (input valid, chosen_index, chosen_unvisited, chosen_score,
                too_many_children, output ready);
endinterface

[rtl/core/ucbs_datapath.sv]
module ucbs_datapath
  import ucbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ucbs_cmd_t          cmd_i,
  output ucbs_sts_t          sts_o,
  input  logic [23:0]        parent_visits_i,
  input  logic [23:0]        child_visits_i,
  input  logic signed [31:0] child_value_i,
  input  logic               last_child_i,
  output logic [5:0]         best_index_o,
  output logic               unvisited_o,
  output logic signed [39:0] best_score_o,
  output logic               overflow_o
);

  // captured request
  logic [23:0] pv_q, cv_q;
  logic signed [31:0] val_q;
  logic last_q;

  // selection state
  logic [CountW-1:0] count_q, count_d;
  logic [5:0] best_idx_q, best_idx_d;
  logic signed [39:0] best_q, best_d;
  logic unv_q, unv_d, ovf_q, ovf_d;
  logic [31:0] plog_q, plog_d;

  // log unit
  logic [31:0] x_q, x_d;
  logic [31:0] l2_q, l2_d;
  logic [4:0]  bit_q, bit_d;
  logic [63:0] sq;
  logic [33:0] sq_sh;
  logic [4:0]  topk;
  logic [47:0] mlo_q, mlo_d;

  // divider: magnitude of value / n and plog / n, shared counter
  logic [31:0] va_q, va_d, vq_q, vq_d;
  logic [24:0] vr_q, vr_d;
  logic [31:0] lq_q, lq_d;
  logic [31:0] la_q, la_d;
  logic [24:0] lr_q, lr_d;
  logic [24:0] vr_t, lr_t;

  // square root
  logic [39:0] sa_q, sa_d;
  logic [20:0] root_q, root_d;
  logic [20:0] trial;
  logic [41:0] tsq;

  logic signed [39:0] score_q, score_d;
  logic signed [41:0] sum;
  logic signed [32:0] exploit;

  // top set bit of parent visits
  always_comb begin
    topk = '0;
    for (int i = 0; i < 24; i++) begin
      if (pv_q[i]) topk = 5'(i);
    end
  end

  assign sq    = 64'(x_q) * 64'(x_q);
  assign sq_sh = sq[63:30];
  assign vr_t  = {vr_q[23:0], va_q[31]};
  assign lr_t  = {lr_q[23:0], la_q[31]};
  assign trial = root_q | (21'd1 << bit_q);
  assign tsq   = 42'(trial) * 42'(trial);
  assign exploit = val_q[31] ? -$signed({1'b0, vq_q}) : $signed({1'b0, vq_q});
  assign sum = 42'(exploit) + 42'($signed({1'b0, root_q, 1'b0}));

  always_comb begin
    x_d = x_q; l2_d = l2_q; bit_d = bit_q; mlo_d = mlo_q; plog_d = plog_q;
    va_d = va_q; vq_d = vq_q; vr_d = vr_q; la_d = la_q; lq_d = lq_q; lr_d = lr_q;
    sa_d = sa_q; root_d = root_q; score_d = score_q;
    count_d = count_q; best_idx_d = best_idx_q; best_d = best_q;
    unv_d = unv_q; ovf_d = ovf_q;

    // log2 mantissa setup
    if (cmd_i.ln_init) begin
      x_d   = 32'({8'd0, pv_q} << (5'd30 - topk));
      l2_d  = {3'd0, topk, 24'd0};
      bit_d = 5'd23;
    end
    // one squaring round
    if (cmd_i.ln_step) begin
      if (sq_sh[31]) begin
        l2_d[bit_q] = 1'b1;
        x_d = sq_sh[32:1];
      end else begin
        x_d = sq_sh[31:0];
      end
      bit_d = bit_q - 5'd1;
    end
    // ln2 scaling in two 32x16 partial products
    if (cmd_i.ln_mul0) mlo_d = 48'(Ln2Q32) * 48'(l2_q[15:0]);
    if (cmd_i.ln_mul1) begin
      plog_d = (pv_q <= 24'd1) ? '0 :
               32'((64'(48'(Ln2Q32) * 48'(l2_q[31:16])) + 64'(mlo_q[47:16])) >> 16);
    end
    // divisions
    if (cmd_i.div_init) begin
      va_d = val_q[31] ? 32'(-val_q) : val_q;
      vr_d = '0; vq_d = '0;
      la_d = plog_q; lr_d = '0; lq_d = '0;
      bit_d = 5'd31;
    end
    if (cmd_i.div_step) begin
      va_d = {va_q[30:0], 1'b0};
      la_d = {la_q[30:0], 1'b0};
      if (vr_t >= {1'b0, cv_q}) begin
        vr_d = vr_t - {1'b0, cv_q}; vq_d = {vq_q[30:0], 1'b1};
      end else begin
        vr_d = vr_t; vq_d = {vq_q[30:0], 1'b0};
      end
      if (lr_t >= {1'b0, cv_q}) begin
        lr_d = lr_t - {1'b0, cv_q}; lq_d = {lq_q[30:0], 1'b1};
      end else begin
        lr_d = lr_t; lq_d = {lq_q[30:0], 1'b0};
      end
      bit_d = bit_q - 5'd1;
    end
    // integer square root
    if (cmd_i.sqrt_init) begin
      sa_d = {lq_q, 8'd0}; root_d = '0; bit_d = 5'd20;
    end
    if (cmd_i.sqrt_step) begin
      if (tsq <= 42'(sa_q)) root_d = trial;
      bit_d = bit_q - 5'd1;
    end
    // score with saturation
    if (cmd_i.score) begin
      if (sum > 42'(ScoreMax)) score_d = ScoreMax;
      else if (sum < 42'(ScoreMin)) score_d = ScoreMin;
      else score_d = sum[39:0];
    end
    // running best
    if (cmd_i.update) begin
      if (count_q >= CountW'(MaxChildren)) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
        if (!unv_q) begin
          if (cv_q == '0) begin
            unv_d = 1'b1; best_idx_d = 6'(count_q); best_d = '0;
          end else if (score_q > best_q) begin
            best_d = score_q; best_idx_d = 6'(count_q);
          end
        end
      end
    end
    if (cmd_i.clear) begin
      count_d = '0; best_idx_d = '0; best_d = ScoreMin; unv_d = 1'b0; ovf_d = 1'b0;
      plog_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; best_idx_q <= '0; best_q <= ScoreMin;
      unv_q <= 1'b0; ovf_q <= 1'b0; plog_q <= '0; bit_q <= '0;
    end else begin
      count_q <= count_d; best_idx_q <= best_idx_d; best_q <= best_d;
      unv_q <= unv_d; ovf_q <= ovf_d; plog_q <= plog_d; bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pv_q <= parent_visits_i; cv_q <= child_visits_i;
      val_q <= child_value_i; last_q <= last_child_i;
    end
    x_q <= x_d; l2_q <= l2_d; mlo_q <= mlo_d;
    va_q <= va_d; vq_q <= vq_d; vr_q <= vr_d;
    la_q <= la_d; lq_q <= lq_d; lr_q <= lr_d;
    sa_q <= sa_d; root_q <= root_d; score_q <= score_d;
  end

  assign sts_o.first    = (count_q == '0);
  assign sts_o.overflow = (count_q >= CountW'(MaxChildren));
  assign sts_o.skip     = unv_q || (cv_q == '0);
  assign sts_o.last     = last_q;

  assign best_index_o = best_idx_q;
  assign unvisited_o  = unv_q;
  assign best_score_o = best_q;
  assign overflow_o   = ovf_q;

  // bit counter end is read by the controller through step counts
endmodule

[rtl/core/ucbs_ctrl.sv]
module ucbs_ctrl
  import ucbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ucbs_sts_t sts_i,
  output ucbs_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StLnSq;
          cnt_d = 6'd0;
        end
      end
      StLnSq: begin
        // first child computes ln N, others go straight on
        if (!sts_i.first) begin
          state_d = sts_i.overflow ? StUpdate : StDiv;
          cmd_o.div_init = 1'b1;
        end else if (cnt_q == 6'd0) begin
          cmd_o.ln_init = 1'b1; cnt_d = 6'd1;
        end else begin
          cmd_o.ln_step = 1'b1;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd24) begin
            state_d = StLnMul; cnt_d = 6'd0;
          end
        end
      end
      StLnMul: begin
        if (cnt_q == 6'd0) begin
          cmd_o.ln_mul0 = 1'b1; cnt_d = 6'd1;
        end else begin
          cmd_o.ln_mul1 = 1'b1; cnt_d = 6'd0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.overflow || sts_i.skip) begin
          state_d = StUpdate;
        end else if (cnt_q == 6'd0) begin
          cmd_o.div_init = 1'b1; cnt_d = 6'd1;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            state_d = StSqrt; cnt_d = 6'd0;
          end
        end
      end
      StSqrt: begin
        if (cnt_q == 6'd0) begin
          cmd_o.sqrt_init = 1'b1; cnt_d = 6'd1;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd21) state_d = StScore;
        end
      end
      StScore: begin
        cmd_o.score = 1'b1;
        state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = sts_i.last ? StOut : StIdle;
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/ucb1_child_select_unit.sv]
// UCB1 child selection: children of one node arrive one request at a time and
// the block keeps the first unvisited child, else the one with the highest
// v/n + 2*sqrt(ln(N)/n). A scored child is captured, dispatched, run through
// two 32-step restoring dividers sharing a counter (v/n and ln(N)/n), the
// 21-step square root, score and update before the next is taken. The first
// child of a selection adds the 24-round log2 squaring loop and ln2 scaling.
// Unvisited and skipped children bypass divide, root and score; those past
// the limit go straight to update. The result appears in the cycle after the
// last child's update, held until taken; no new request is accepted until then.
module ucb1_child_select_unit
  import ucbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ucbs_in_if.sink    in_if,
  ucbs_out_if.source out_if
);

  ucbs_cmd_t cmd;
  ucbs_sts_t sts;

  ucbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ucbs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .parent_visits_i (in_if.parent_visits),
    .child_visits_i  (in_if.child_visits),
    .child_value_i   (in_if.child_value),
    .last_child_i    (in_if.last_child),
    .best_index_o    (out_if.chosen_index),
    .unvisited_o     (out_if.chosen_unvisited),
    .best_score_o    (out_if.chosen_score),
    .overflow_o      (out_if.too_many_children)
  );

endmodule

[test/ucbs_in_if.sv]
`timescale 1ns / 100ps
// request and result interfaces come from the rtl tree

[test/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import ucbs_pkg::*;

  typedef struct {
    logic [5:0]         index;
    logic               unvisited;
    logic signed [39:0] score;
    logic               overflow;
  } choice_t;

  // running selection and queue of expected choices
  class choice_board;
    choice_t            pending[$];
    logic signed [39:0] best_score;
    logic [5:0]         best_index;
    int unsigned        count;
    bit                 unvisited_seen;
    bit                 overflow_seen;
    logic [31:0]        parent_ln;
    int                 errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      best_score = ScoreMin;
      best_index = '0;
      count = 0;
      unvisited_seen = 0;
      overflow_seen = 0;
      parent_ln = '0;
    endfunction

    // ln(N) in Q8.24 via log2 by repeated squaring
    function logic [31:0] ln_q24(logic [23:0] nv);
      int unsigned k;
      logic [63:0] x, lg;
      logic [95:0] prod;
      k = 0;
      if (nv <= 1) return '0;
      for (int i = 0; i < 24; i++) if (nv[i]) k = i;
      x = 64'(nv) << (30 - k);
      lg = 64'(k) << 24;
      for (int i = 23; i >= 0; i--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          lg[i] = 1'b1;
          x = x >> 1;
        end
      end
      prod = 96'(lg) * 96'(Ln2Q32);
      return prod[63:32];
    endfunction

    function logic [63:0] root_of(logic [63:0] a);
      logic [63:0] r, t;
      r = 0;
      for (int i = 20; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= a) r = t;
      end
      return r;
    endfunction

    function void note_request(logic [23:0] pv, logic [23:0] cv,
                               logic signed [31:0] val, logic last);
      longint exploit, explore, sc;
      logic [63:0] q;
      choice_t e;
      if (count == 0) parent_ln = ln_q24(pv);
      if (count >= MaxChildren) overflow_seen = 1;
      else begin
        if (!unvisited_seen) begin
          if (cv == 0) begin
            unvisited_seen = 1;
            best_index = count[5:0];
            best_score = '0;
          end else begin
            exploit = longint'(val) / longint'(cv);
            q = 64'(parent_ln) / 64'(cv);
            explore = 2 * longint'(root_of(q << 8));
            sc = exploit + explore;
            if (sc > longint'(ScoreMax)) sc = ScoreMax;
            if (sc < longint'(ScoreMin)) sc = ScoreMin;
            if (sc > longint'(best_score)) begin
              best_score = sc[39:0];
              best_index = count[5:0];
            end
          end
        end
        count++;
      end
      if (last) begin
        e = '{best_index, unvisited_seen, best_score, overflow_seen};
        pending.insert(pending.size(), e);
        clear();
      end
    endfunction

    function void check_choice(logic [5:0] idx, logic unv, logic signed [39:0] sc,
                               logic ovf);
      choice_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected choice idx=%0d score=%0d", $time, idx, sc);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.index) begin
        $display("%0t: index exp %0d got %0d", $time, e.index, idx);
        errors++;
      end
      if (unv !== e.unvisited) begin
        $display("%0t: unvisited exp %0b got %0b", $time, e.unvisited, unv);
        errors++;
      end
      if (sc !== e.score) begin
        $display("%0t: score exp %0d got %0d", $time, e.score, sc);
        errors++;
      end
      if (ovf !== e.overflow) begin
        $display("%0t: overflow exp %0b got %0b", $time, e.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  ucbs_in_if  req_if();
  ucbs_out_if res_if();
  choice_board board;

  int  sent;
  bit  calm;
  bit  stim_done;
  int  hold_len;
  int  idle_cycles;

  ucb1_child_select_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (req_if.sink),
    .out_if(res_if.source)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    rst_ni = 0;
    req_if.valid = 0;
    req_if.parent_visits = '0;
    req_if.child_visits = '0;
    req_if.child_value = '0;
    req_if.last_child = 0;
    res_if.ready = 0;
    calm = 0;
    stim_done = 0;
    hold_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        board.check_choice(res_if.chosen_index, res_if.chosen_unvisited,
                           res_if.chosen_score, res_if.too_many_children);
      if (hold_len > 0) begin
        hold_len <= hold_len - 1;
        res_if.ready <= 0;
      end else
        res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
    end
  end

  // watchdog on accepted handshakes
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // offer one child request and wait until it is taken
  task automatic send_child(logic [23:0] pv, logic [23:0] cv, logic [31:0] val,
                            logic last);
    while (!calm && $urandom_range(99) < 22) begin
      req_if.valid <= 0;
      @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.parent_visits <= pv;
    req_if.child_visits <= cv;
    req_if.child_value <= val;
    req_if.last_child <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(pv, cv, val, last);
    sent++;
  endtask

  function automatic logic [23:0] rand_visits();
    case ($urandom_range(3))
      0: return 24'($urandom_range(1, 8));
      1: return 24'($urandom_range(1, 1000));
      2: return 24'hFFFFFF - 24'($urandom_range(3));
      default: return 24'($urandom);
    endcase
  endfunction

  // one selection of cnt children with random content
  task automatic send_node(int cnt);
    logic [23:0] pv;
    logic [23:0] cv;
    pv = rand_visits();
    if ($urandom_range(9) == 0) pv = 24'($urandom_range(1));
    for (int i = 0; i < cnt; i++) begin
      cv = ($urandom_range(11) == 0) ? 24'd0 : rand_visits();
      send_child($urandom_range(9) == 0 ? rand_visits() : pv, cv, $urandom, i == cnt - 1);
    end
  endtask

  initial begin
    sent = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: extremes, ties, small parent, unvisited
    send_child(24'd0, 24'd1, 32'h7FFFFFFF, 1);
    send_child(24'd1, 24'd1, 32'h80000000, 0);
    send_child(24'd1, 24'd1, 32'h80000000, 1);
    send_child(24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 0);
    send_child(24'd0, 24'd1, 32'd0, 0);
    send_child(24'd0, 24'd1, 32'd0, 1);
    send_child(24'd100, 24'd5, 32'd65536, 0);
    send_child(24'd0, 24'd0, 32'd12345, 0);
    send_child(24'd0, 24'd3, 32'h7FFFFFFF, 1);
    send_child(24'd2, 24'd0, 32'h80000000, 1);
    send_child(24'hAAAAAA, 24'h555555, 32'h55555555, 0);
    send_child(24'h555555, 24'hAAAAAA, 32'hAAAAAAAA, 1);
    // overflow selection, past the 64-child limit
    for (int i = 0; i < 70; i++)
      send_child(24'd50, 24'(i + 1), $urandom, i == 69);
    // sender pause until every choice has come
    req_if.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    // long receiver hold-off while children keep coming
    hold_len = 400;
    for (int i = 0; i < 6; i++) send_node(2);
    // long calm stretch
    calm = 1;
    for (int i = 0; i < 20; i++) send_node($urandom_range(1, 4));
    calm = 0;
    while (sent < 700) begin
      if ($urandom_range(19) == 0) send_node($urandom_range(60, 68));
      else send_node($urandom_range(1, 6));
    end
    req_if.valid <= 0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
